/* rtl/gps_pkg.sv */
// ---------------------------------------------------------------------------
// Gaussian polar sampler package
// Shared widths, stage map, payload types and the square-root step.
// ---------------------------------------------------------------------------
package gps_pkg;

  localparam int UNIFORM_BITS = 24;
  localparam int OUTPUT_BITS  = 24;
  localparam int VFRAC        = 30;
  localparam int LOGFRAC      = 28;
  localparam int MEAN_W       = 24;
  localparam int DEV_W        = 16;
  localparam int CFG_W        = 24;
  localparam int SUM_W        = 36;

  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  // configuration register indexes
  localparam logic CFG_MEAN = 1'b0;
  localparam logic CFG_DEV  = 1'b1;

  // stage map
  localparam int ST_VMAG    = 0;
  localparam int ST_SQUARE  = 1;
  localparam int ST_RSUM    = 2;
  localparam int ST_NORM0   = 3;
  localparam int ST_NORM_N  = 6;
  localparam int ST_SSQ0    = 3;
  localparam int ST_SSQ_N   = 30;
  localparam int ST_XLOAD   = ST_NORM0 + ST_NORM_N;
  localparam int ST_LOG0    = ST_XLOAD + 1;
  localparam int ST_LFORM   = ST_LOG0 + LOGFRAC;
  localparam int ST_LN2     = ST_LFORM + 1;
  localparam int ST_GSQ0    = ST_LN2 + 1;
  localparam int ST_GSQ_N   = 20;
  localparam int ST_MULG    = ST_GSQ0 + ST_GSQ_N;
  localparam int ST_NUM     = ST_MULG + 1;
  localparam int ST_DIVPRE  = ST_NUM + 1;
  localparam int QBITS      = 17;
  localparam int ST_DIV0    = ST_DIVPRE + 1;
  localparam int ST_CLAMP   = ST_DIV0 + QBITS;
  localparam int ST_SCALE   = ST_CLAMP + 1;
  localparam int ST_FINAL   = ST_SCALE + 1;
  localparam int NST        = ST_FINAL + 1;

  localparam logic signed [SUM_W-1:0] OUT_MAX =
    SUM_W'((64'd1 << (OUTPUT_BITS - 1)) - 64'd1);
  localparam logic signed [SUM_W-1:0] OUT_MIN = ~OUT_MAX;

  typedef struct packed {
    logic [31:0] rem;
    logic [29:0] root;
  } sq_t;

  typedef struct packed {
    logic                   ok;
    logic [1:0][VFRAC:0]    m;
    logic [1:0]             n;
    logic [1:0][61:0]       sq;
    logic [59:0]            nrm;
    logic [5:0]             c;
    logic [59:0]            srad;
    sq_t                    s;
    logic [VFRAC:0]         x;
    logic [LOGFRAC-1:0]     frac;
    logic [33:0]            l;
    logic [39:0]            grad;
    sq_t                    g;
    logic [1:0][50:0]       pr;
    logic [1:0][51:0]       num;
    logic [1:0]             ovf;
    logic [1:0][51:0]       dr;
    logic [1:0][QBITS-1:0]  q;
    logic [1:0][16:0]       z;
    logic [1:0]             clip;
    logic [1:0][33:0]       pp;
    logic [1:0][OUTPUT_BITS-1:0] val;
  } st_t;

  typedef struct packed {
    logic [1:0][OUTPUT_BITS-1:0] val;
    logic [1:0]                  clip;
  } pair_t;

  // one digit of a restoring square root
  function automatic sq_t sqrt_step(sq_t cur, logic [1:0] bits);
    logic [33:0] r2;
    logic [33:0] trial;
    sq_t         res;
    r2    = {cur.rem, bits};
    trial = {2'b00, cur.root, 2'b01};
    if (r2 >= trial) begin
      res.rem  = 32'(r2 - trial);
      res.root = {cur.root[28:0], 1'b1};
    end else begin
      res.rem  = r2[31:0];
      res.root = {cur.root[28:0], 1'b0};
    end
    return res;
  endfunction

endpackage

/* rtl/gaussian_polar_sample_generator_top.sv */
// ---------------------------------------------------------------------------
// Gaussian polar sample generator
// Uniform pair in, two normal samples out (second lane first), pairs rejected
// outside the unit circle produce nothing.
// ---------------------------------------------------------------------------
// A pair passes through the 83 pipeline registers, the first loaded at the
// accepting edge, then the output register; the second sample follows once
// the first is taken. The single output port carries both samples of a pair,
// so a new pair loads only when the buffer is empty or its last sample leaves;
// a rejected pair still uses an input slot but produces no sample.
// Reset clears all pipeline valids and the output, sets the mean to 0 and
// the deviation to 4096.
module gaussian_polar_sample_generator_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [gps_pkg::UNIFORM_BITS-1:0]    uniform_first,
  input  logic [gps_pkg::UNIFORM_BITS-1:0]    uniform_second,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [gps_pkg::OUTPUT_BITS-1:0]     sample_value,
  output logic                                last_of_pair,
  output logic                                clipped,
  input  logic                                cfg_write,
  input  logic                                cfg_index,
  input  logic [gps_pkg::CFG_W-1:0]           cfg_data
);

  logic signed [gps_pkg::MEAN_W-1:0] mean_offset;
  logic [gps_pkg::DEV_W-1:0]         deviation_scale;

  logic           core_valid;
  gps_pkg::pair_t core_pair;
  gps_pkg::pair_t obuf;
  logic [1:0]     cnt;
  logic           adv;
  logic           out_take;
  logic           load_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_offset     <= '0;
      deviation_scale <= gps_pkg::DEV_W'(4096);
    end else if (cfg_write) begin
      case (cfg_index)
        gps_pkg::CFG_MEAN: mean_offset     <= cfg_data[gps_pkg::MEAN_W-1:0];
        gps_pkg::CFG_DEV:  deviation_scale <= cfg_data[gps_pkg::DEV_W-1:0];
        default: ;
      endcase
    end
  end

  gps_core u_core (
    .clk            (clk),
    .rst            (rst),
    .adv            (adv),
    .in_valid       (in_valid),
    .uniform_first  (uniform_first),
    .uniform_second (uniform_second),
    .mean           (mean_offset),
    .dev            (deviation_scale),
    .res_valid      (core_valid),
    .res            (core_pair)
  );

  assign out_take = out_valid & ~out_stall;
  // take a new pair when the buffer is empty or its last sample leaves now
  assign load_ok  = (cnt == 2'd0) || ((cnt == 2'd1) && out_take);
  assign adv      = ~core_valid | load_ok;
  assign in_stall = ~adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (core_valid && load_ok) begin
      cnt <= 2'd2;
    end else if (out_take) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (core_valid && load_ok) begin
      obuf <= core_pair;
    end
  end

  assign out_valid    = (cnt != 2'd0);
  assign last_of_pair = (cnt == 2'd1);
  assign sample_value = last_of_pair ? obuf.val[0] : obuf.val[1];
  assign clipped      = last_of_pair ? obuf.clip[0] : obuf.clip[1];

endmodule

/* rtl/gps_core.sv */
// ---------------------------------------------------------------------------
// Gaussian polar sampler datapath
// Stall-enabled pipeline from a uniform pair to two scaled samples.
// ---------------------------------------------------------------------------
module gps_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  logic                                in_valid,
  input  logic [gps_pkg::UNIFORM_BITS-1:0]    uniform_first,
  input  logic [gps_pkg::UNIFORM_BITS-1:0]    uniform_second,
  input  logic signed [gps_pkg::MEAN_W-1:0]   mean,
  input  logic [gps_pkg::DEV_W-1:0]           dev,
  output logic                                res_valid,
  output gps_pkg::pair_t                      res
);

  localparam int UB   = gps_pkg::UNIFORM_BITS;
  localparam int VW   = gps_pkg::VFRAC + 1;
  localparam int TW   = UB + 1 + gps_pkg::VFRAC;
  localparam int NST  = gps_pkg::NST;

  gps_pkg::st_t stg [NST];
  gps_pkg::st_t nxt [NST];
  logic [NST-1:0] vld;

  for (genvar k = 0; k < NST; k++) begin : g_stage
    if (k == 0) begin : g_first
      always_comb begin
        logic [1:0][UB-1:0] u;
        logic [UB:0]        twice;
        logic [UB:0]        mag;
        logic [TW-1:0]      wide;
        nxt[k]    = '0;
        nxt[k].ok = 1'b1;
        u[0] = uniform_first;
        u[1] = uniform_second;
        for (int ln = 0; ln < 2; ln++) begin
          twice = {u[ln], 1'b0};
          if (twice[UB]) begin
            mag = twice - ((UB+1)'(1) << UB);
            nxt[k].n[ln] = 1'b0;
          end else begin
            mag = ((UB+1)'(1) << UB) - twice;
            nxt[k].n[ln] = 1'b1;
          end
          wide = {mag, {gps_pkg::VFRAC{1'b0}}} >> UB;
          nxt[k].m[ln] = wide[VW-1:0];
        end
      end
    end else begin : g_rest
      always_comb begin
        gps_pkg::st_t d;
        logic [62:0]  rsum;
        logic [61:0]  lsq;
        logic [63:0]  lprod;
        logic [52:0]  dlim;
        logic [51:0]  dsub;
        logic [16:0]  mag;
        logic signed [33:0] qs;
        logic signed [gps_pkg::SUM_W-1:0] sum;
        d     = stg[k-1];
        rsum  = '0;
        lsq   = '0;
        lprod = '0;
        dlim  = '0;
        dsub  = '0;
        mag   = '0;
        qs    = '0;
        sum   = '0;
        if (k == gps_pkg::ST_SQUARE) begin
          for (int ln = 0; ln < 2; ln++) begin
            d.sq[ln] = 62'(d.m[ln]) * 62'(d.m[ln]);
          end
        end
        if (k == gps_pkg::ST_RSUM) begin
          rsum   = 63'(d.sq[0]) + 63'(d.sq[1]);
          // drop pairs outside the open unit circle, and the origin
          d.ok   = (rsum != '0) && (rsum[62:60] == 3'b000);
          d.nrm  = rsum[59:0];
          d.srad = rsum[59:0];
          d.c    = '0;
          d.s    = '0;
        end
        if (k >= gps_pkg::ST_NORM0 && k < gps_pkg::ST_NORM0 + gps_pkg::ST_NORM_N) begin
          if ((d.nrm >> (60 - (32 >> (k - gps_pkg::ST_NORM0)))) == '0) begin
            d.nrm = d.nrm << (32 >> (k - gps_pkg::ST_NORM0));
            d.c   = d.c + 6'(32 >> (k - gps_pkg::ST_NORM0));
          end
        end
        if (k >= gps_pkg::ST_SSQ0 && k < gps_pkg::ST_SSQ0 + gps_pkg::ST_SSQ_N) begin
          d.s    = gps_pkg::sqrt_step(d.s, d.srad[59:58]);
          d.srad = {d.srad[57:0], 2'b00};
        end
        if (k == gps_pkg::ST_XLOAD) begin
          d.x    = d.nrm[59:29];
          d.frac = '0;
        end
        if (k >= gps_pkg::ST_LOG0 && k < gps_pkg::ST_LOG0 + gps_pkg::LOGFRAC) begin
          lsq = 62'(d.x) * 62'(d.x);
          if (lsq[61]) begin
            d.x    = lsq[61:31];
            d.frac = d.frac | (gps_pkg::LOGFRAC'(1) <<
                               (gps_pkg::LOGFRAC - 1 - (k - gps_pkg::ST_LOG0)));
          end else begin
            d.x = lsq[60:30];
          end
        end
        if (k == gps_pkg::ST_LFORM) begin
          d.l = ((34'(d.c) + 34'd1) << gps_pkg::LOGFRAC) - 34'(d.frac);
        end
        if (k == gps_pkg::ST_LN2) begin
          lprod  = 64'(d.l) * 64'(gps_pkg::LN2_Q30);
          d.grad = {1'b0, lprod[63:25]};
          d.g    = '0;
        end
        if (k >= gps_pkg::ST_GSQ0 && k < gps_pkg::ST_GSQ0 + gps_pkg::ST_GSQ_N) begin
          d.g    = gps_pkg::sqrt_step(d.g, d.grad[39:38]);
          d.grad = {d.grad[37:0], 2'b00};
        end
        if (k == gps_pkg::ST_MULG) begin
          for (int ln = 0; ln < 2; ln++) begin
            d.pr[ln] = 51'(d.m[ln]) * 51'(d.g.root[19:0]);
          end
        end
        if (k == gps_pkg::ST_NUM) begin
          for (int ln = 0; ln < 2; ln++) begin
            d.num[ln] = 52'(d.pr[ln]) + 52'({d.s.root, 3'b000});
          end
        end
        if (k == gps_pkg::ST_DIVPRE) begin
          dlim = 53'({d.s.root, 4'b0000, {gps_pkg::QBITS{1'b0}}});
          for (int ln = 0; ln < 2; ln++) begin
            d.ovf[ln] = 53'(d.num[ln]) >= dlim;
            d.dr[ln]  = d.num[ln];
            d.q[ln]   = '0;
          end
        end
        if (k >= gps_pkg::ST_DIV0 && k < gps_pkg::ST_DIV0 + gps_pkg::QBITS) begin
          dsub = 52'({d.s.root, 4'b0000}) << (gps_pkg::QBITS - 1 - (k - gps_pkg::ST_DIV0));
          for (int ln = 0; ln < 2; ln++) begin
            if (d.dr[ln] >= dsub) begin
              d.dr[ln] = d.dr[ln] - dsub;
              d.q[ln]  = d.q[ln] | (gps_pkg::QBITS'(1) <<
                                    (gps_pkg::QBITS - 1 - (k - gps_pkg::ST_DIV0)));
            end
          end
        end
        if (k == gps_pkg::ST_CLAMP) begin
          for (int ln = 0; ln < 2; ln++) begin
            mag        = d.q[ln];
            d.clip[ln] = 1'b0;
            if (d.n[ln]) begin
              if (d.ovf[ln] || mag > 17'd32768) begin
                mag        = 17'd32768;
                d.clip[ln] = 1'b1;
              end
              d.z[ln] = 17'(~mag + 17'd1);
            end else begin
              if (d.ovf[ln] || mag > 17'd32767) begin
                mag        = 17'd32767;
                d.clip[ln] = 1'b1;
              end
              d.z[ln] = mag;
            end
          end
        end
        if (k == gps_pkg::ST_SCALE) begin
          for (int ln = 0; ln < 2; ln++) begin
            d.pp[ln] = 34'($signed({1'b0, dev}) * $signed(d.z[ln]));
          end
        end
        if (k == gps_pkg::ST_FINAL) begin
          for (int ln = 0; ln < 2; ln++) begin
            // round half up, dropping 12 fraction bits, then add the mean
            qs  = ($signed(d.pp[ln]) + 34'sd2048) >>> 12;
            sum = gps_pkg::SUM_W'(mean) + gps_pkg::SUM_W'(qs);
            if (sum > gps_pkg::OUT_MAX) begin
              sum        = gps_pkg::OUT_MAX;
              d.clip[ln] = 1'b1;
            end
            if (sum < gps_pkg::OUT_MIN) begin
              sum        = gps_pkg::OUT_MIN;
              d.clip[ln] = 1'b1;
            end
            d.val[ln] = sum[gps_pkg::OUTPUT_BITS-1:0];
          end
        end
        nxt[k] = d;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        vld[k] <= vld[k-1] & nxt[k].ok;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NST; k++) begin
        stg[k] <= nxt[k];
      end
    end
  end

  assign res_valid = vld[NST-1];
  assign res.val   = stg[NST-1].val;
  assign res.clip  = stg[NST-1].clip;

endmodule
